/* design/eoip_pkg.sv */
// ----------------------------------------------------------------------------
// eoip_pkg: shared definitions for the increasing-weight path engine
// Field widths of the edge beat and the sequencer state encoding.
// ----------------------------------------------------------------------------
package eoip_pkg;

  localparam int unsigned FROM_W   = 6;
  localparam int unsigned TO_W     = 6;
  localparam int unsigned WEIGHT_W = 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_LEN,
    ST_UPDATE,
    ST_OUT
  } eoip_state_e;

endpackage

/* design/edge_ordered_increasing_path_dp_core.sv */
// ----------------------------------------------------------------------------
// edge_ordered_increasing_path_dp_core: longest increasing-weight path engine
// Per-vertex max segment trees over weight, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage. Each input beat carries one directed edge (source, target, weight).
// The block returns one output beat per edge: the length of the longest path
// with strictly increasing weights, in arrival order, that ends with this
// edge, and the running best over all edges so far. Lengths saturate.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. One edge is handled at a time and in_stall_o stays high until the
// result beat has been taken.
// Sequence: an edge is accepted in an idle cycle. The prefix query then walks
// the source vertex's tree upward, each step checking first the left and then
// the right bound of its range, and ends with a closing check. The length is
// then formed. The update walk reads one node per level from leaf to root
// while writing back the node read before, and then finishes the last write.
// The result beat is then offered, and the input reopens once it has gone: a
// new edge is not taken before the last one is through. The walks go step by
// step because the tree memory has a single read port and a single write port.
// After reset the tree memory is swept to zero, one entry per cycle, over all
// 2^(clog2(VERTICES) + clog2(2*WEIGHT_LEVELS)) entries (32768 at the
// defaults); input beats are stalled during the sweep. A stalled result
// simply holds its values until the receiver takes it.
module edge_ordered_increasing_path_dp_core #(
  parameter int unsigned VERTICES      = 64,
  parameter int unsigned WEIGHT_LEVELS = 256,
  parameter int unsigned LENGTH_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [eoip_pkg::FROM_W-1:0]   from_vertex_i,
  input  logic [eoip_pkg::TO_W-1:0]     to_vertex_i,
  input  logic [eoip_pkg::WEIGHT_W-1:0] edge_weight_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [LENGTH_BITS-1:0]       path_length_o,
  output logic [LENGTH_BITS-1:0]       best_length_o
);
  import eoip_pkg::*;

  // Vertex bits, node bits and the wider walk index that can hold 2*W.
  localparam int unsigned VB    = $clog2(VERTICES);
  localparam int unsigned NB    = $clog2(2 * WEIGHT_LEVELS);
  localparam int unsigned IW    = NB + 1;
  localparam int unsigned AW    = VB + NB;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned RW    = VB + 1;
  localparam int unsigned CW    = (IW > WEIGHT_W) ? IW : WEIGHT_W;

  // Vertex number reduced modulo VERTICES, one restoring step per input bit.
  function automatic logic [VB-1:0] vtx_mod(input logic [FROM_W-1:0] x);
    logic [RW-1:0] r;
    r = '0;
    for (int i = FROM_W - 1; i >= 0; i--) begin
      r = {r[RW-2:0], x[i]};
      if (r >= RW'(VERTICES)) begin
        r = r - RW'(VERTICES);
      end
    end
    return r[VB-1:0];
  endfunction

  eoip_state_e state_q, state_d;

  logic [AW-1:0]          clr_cnt_q, clr_cnt_d;
  logic [VB-1:0]          src_q, src_d;
  logic [VB-1:0]          dst_q, dst_d;
  logic                   upd_q, upd_d;
  logic [IW-1:0]          lo_q, lo_d;
  logic [IW-1:0]          hi_q, hi_d;
  logic                   ph_q, ph_d;
  logic [LENGTH_BITS-1:0] res_q, res_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] best_q, best_d;
  logic [IW-1:0]          rd_i_q, rd_i_d;
  logic [IW-1:0]          wr_i_q, wr_i_d;
  logic                   pend_q, pend_d;
  logic [LENGTH_BITS-1:0] rdata_q;

  // Memory port controls.
  logic                   mem_re, mem_we;
  logic [AW-1:0]          mem_raddr, mem_waddr;
  logic [LENGTH_BITS-1:0] mem_wdata;

  logic                   in_fire;
  logic [CW-1:0]          w_ext;
  logic                   w_in_range;
  logic [IW-1:0]          upto;
  logic [IW-1:0]          hi_m1;
  logic [LENGTH_BITS-1:0] len_sat;
  logic [LENGTH_BITS-1:0] merged;

  assign in_fire    = in_valid_i && (state_q == ST_IDLE);
  assign w_ext      = CW'(edge_weight_i);
  assign w_in_range = w_ext < CW'(WEIGHT_LEVELS);
  assign upto       = w_in_range ? IW'(edge_weight_i) : IW'(WEIGHT_LEVELS);
  assign hi_m1      = hi_q - IW'(1);
  assign len_sat    = (res_q == '1) ? res_q : res_q + LENGTH_BITS'(1);
  assign merged     = (rdata_q > len_q) ? rdata_q : len_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_QUERY;
        end
      end
      ST_QUERY: begin
        if (!ph_q && (lo_q >= hi_q)) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        state_d = upd_q ? ST_UPDATE : ST_OUT;
      end
      ST_UPDATE: begin
        if ((rd_i_q == '0) && !pend_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    src_d     = src_q;
    dst_d     = dst_q;
    upd_d     = upd_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    ph_d      = ph_q;
    res_d     = res_q;
    len_d     = len_q;
    best_d    = best_q;
    rd_i_d    = rd_i_q;
    wr_i_d    = wr_i_q;
    pend_d    = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = '0;
    mem_waddr = '0;
    mem_wdata = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_fire) begin
          src_d  = vtx_mod(from_vertex_i);
          dst_d  = vtx_mod(to_vertex_i);
          upd_d  = w_in_range;
          lo_d   = IW'(WEIGHT_LEVELS);
          hi_d   = IW'(WEIGHT_LEVELS) + upto;
          ph_d   = 1'b0;
          res_d  = '0;
          rd_i_d = IW'(WEIGHT_LEVELS) + IW'(edge_weight_i);
        end
      end
      ST_QUERY: begin
        // Fold in the node read in the previous cycle.
        if (pend_q && (rdata_q > res_q)) begin
          res_d = rdata_q;
        end
        if (!ph_q) begin
          if (lo_q < hi_q) begin
            if (lo_q[0]) begin
              mem_re    = 1'b1;
              mem_raddr = {src_q, lo_q[NB-1:0]};
              lo_d      = lo_q + IW'(1);
              pend_d    = 1'b1;
            end
            ph_d = 1'b1;
          end
        end else begin
          if (hi_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = {src_q, hi_m1[NB-1:0]};
            pend_d    = 1'b1;
            hi_d      = hi_m1 >> 1;
          end else begin
            hi_d = hi_q >> 1;
          end
          lo_d = lo_q >> 1;
          ph_d = 1'b0;
        end
      end
      ST_LEN: begin
        len_d  = len_sat;
        best_d = (len_sat > best_q) ? len_sat : best_q;
      end
      ST_UPDATE: begin
        // Read the next node up while writing back the one read last cycle.
        if (rd_i_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = {dst_q, rd_i_q[NB-1:0]};
          wr_i_d    = rd_i_q;
          rd_i_d    = rd_i_q >> 1;
          pend_d    = 1'b1;
        end
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = {dst_q, wr_i_q[NB-1:0]};
          mem_wdata = merged;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      pend_q    <= 1'b0;
      ph_q      <= 1'b0;
      best_q    <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      pend_q    <= pend_d;
      ph_q      <= ph_d;
      best_q    <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    dst_q  <= dst_d;
    upd_q  <= upd_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    res_q  <= res_d;
    len_q  <= len_d;
    rd_i_q <= rd_i_d;
    wr_i_q <= wr_i_d;
  end

  // Tree store: one write port and one registered read port.
  logic [LENGTH_BITS-1:0] tree_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= tree_mem[mem_raddr];
    end
  end

  assign path_length_o = len_q;
  assign best_length_o = best_q;

endmodule

/* design/eoip_chk.sv */
// ----------------------------------------------------------------------------
// eoip_chk: port-level checks for the increasing-weight path engine
// Watches the handshakes and the result beat over time.
// ----------------------------------------------------------------------------
module eoip_chk #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [LENGTH_BITS-1:0] path_length_o,
  input logic [LENGTH_BITS-1:0] best_length_o
);

  // A stalled result beat keeps its values.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(path_length_o)
      && $stable(best_length_o))
    else $error("result beat changed while stalled");

  // A path always holds at least the edge itself.
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> path_length_o != '0)
    else $error("zero path length");

  // The running best covers the current path.
  a_best_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> best_length_o >= path_length_o)
    else $error("running best below path length");

  // Only one edge is in flight: no input beat while a result is pending.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  // An accepted edge closes the input; only the stall right after acceptance is checked.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after an accepted beat");

endmodule

bind edge_ordered_increasing_path_dp_core eoip_chk #(
  .LENGTH_BITS(LENGTH_BITS)
) u_eoip_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .path_length_o(path_length_o),
  .best_length_o(best_length_o)
);

/* verif/eoip_path_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eoip_path_checker: scoreboard for the increasing-weight path engine
// Watches both channels, predicts each result beat from its own path tables
// and compares the beats that the engine returns, field by field.
// ----------------------------------------------------------------------------
module eoip_path_checker #(
  parameter int unsigned VERTICES      = 64,
  parameter int unsigned WEIGHT_LEVELS = 256,
  parameter int unsigned LENGTH_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [eoip_pkg::FROM_W-1:0]   from_vertex_i,
  input  logic [eoip_pkg::TO_W-1:0]     to_vertex_i,
  input  logic [eoip_pkg::WEIGHT_W-1:0] edge_weight_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [LENGTH_BITS-1:0]        path_length_i,
  input  logic [LENGTH_BITS-1:0]        best_length_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   pending_o
);

  typedef logic [LENGTH_BITS-1:0] length_t;
  localparam length_t LENGTH_MAX = '1;

  typedef struct packed {
    length_t path;
    length_t best;
  } path_beat_t;

  // Longest path seen so far that ends at a vertex with its last edge at a
  // given weight. A prefix maximum over one row is what a vertex's tree holds.
  length_t     ending_len [VERTICES][WEIGHT_LEVELS];
  length_t     best_len;
  path_beat_t  expected_beats [$];
  int unsigned mismatches;

  function automatic path_beat_t extend_path(input int unsigned src, input int unsigned dst,
                                             input int unsigned weight);
    path_beat_t beat;
    length_t    below;
    below = '0;
    for (int unsigned k = 0; k < WEIGHT_LEVELS && k < weight; k++) begin
      if (ending_len[src][k] > below) below = ending_len[src][k];
    end
    beat.path = (below == LENGTH_MAX) ? LENGTH_MAX : length_t'(below + 1'b1);
    if (weight < WEIGHT_LEVELS && beat.path > ending_len[dst][weight]) begin
      ending_len[dst][weight] = beat.path;
    end
    if (beat.path > best_len) best_len = beat.path;
    beat.best = best_len;
    return beat;
  endfunction

  // The result side is handled first: a result taken at the same edge as a
  // new edge always belongs to an older one.
  always @(posedge clk_i or negedge rst_ni) begin
    path_beat_t want;
    if (!rst_ni) begin
      foreach (ending_len[v, k]) ending_len[v][k] = '0;
      best_len = '0;
      expected_beats.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no edge outstanding: path_length %0d best_length %0d",
                 path_length_i, best_length_i);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (path_length_i !== want.path) begin
            $error("path_length: expected %0d, actual %0d", want.path, path_length_i);
            mismatches++;
          end
          if (best_length_i !== want.best) begin
            $error("best_length: expected %0d, actual %0d", want.best, best_length_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_beats.push_back(extend_path(from_vertex_i % VERTICES,
                                             to_vertex_i % VERTICES, edge_weight_i));
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_beats.size();
  end

endmodule

/* verif/edge_ordered_increasing_path_dp_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_ordered_increasing_path_dp_core_test: top of the path engine bench
// Feeds directed and random edge beats with random idling on both channels,
// one long receiver hold-off, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module edge_ordered_increasing_path_dp_core_test;

  localparam int unsigned VERTICES      = 64;
  localparam int unsigned WEIGHT_LEVELS = 256;
  localparam int unsigned LENGTH_BITS   = 16;

  // Random edges after the directed ones; the groups begun within the last
  // QUIET_EDGES of them run with no idling on either side.
  localparam int unsigned RANDOM_EDGES = 530;
  localparam int unsigned QUIET_EDGES  = 80;

  // The long hold-off starts once this many edge beats have been taken.
  localparam int unsigned HOLD_AFTER  = 150;
  localparam int unsigned HOLD_CYCLES = 400;

  // Run-on time after the last result, longer than any edge takes to its result.
  localparam int unsigned DRAIN_CYCLES = 40;

  // Slowest correct run: the clearing sweep, then the directed and random edges
  // with random sender gaps and receiver stalls, plus the hold-off. The limit
  // lies well above that.
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [eoip_pkg::FROM_W-1:0]   from_vertex;
  logic [eoip_pkg::TO_W-1:0]     to_vertex;
  logic [eoip_pkg::WEIGHT_W-1:0] edge_weight;
  logic                          out_valid;
  logic                          out_stall;
  logic [LENGTH_BITS-1:0]        path_length;
  logic [LENGTH_BITS-1:0]        best_length;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned edges_taken;
  int unsigned cycle_count;
  bit          quiet;

  edge_ordered_increasing_path_dp_core #(
    .VERTICES      (VERTICES),
    .WEIGHT_LEVELS (WEIGHT_LEVELS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .from_vertex_i (from_vertex),
    .to_vertex_i   (to_vertex),
    .edge_weight_i (edge_weight),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .path_length_o (path_length),
    .best_length_o (best_length)
  );

  eoip_path_checker #(
    .VERTICES      (VERTICES),
    .WEIGHT_LEVELS (WEIGHT_LEVELS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) path_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .from_vertex_i    (from_vertex),
    .to_vertex_i      (to_vertex),
    .edge_weight_i    (edge_weight),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .path_length_i    (path_length),
    .best_length_i    (best_length),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit. A hung engine or a lost result beat ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one edge beat and holds it until the engine takes it. Valid stays
  // high into the next beat unless a random gap follows; the payload only
  // changes once the beat has moved.
  task automatic drive_edge(input logic [eoip_pkg::FROM_W-1:0] src,
                            input logic [eoip_pkg::TO_W-1:0] dst,
                            input logic [eoip_pkg::WEIGHT_W-1:0] weight);
    int unsigned gap;
    in_valid    <= 1'b1;
    from_vertex <= src;
    to_vertex   <= dst;
    edge_weight <= weight;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    edges_taken++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Most random traffic goes through a handful of busy vertices, spread so
  // that 0 and 63 are among them, so that paths really do chain up.
  function automatic logic [eoip_pkg::FROM_W-1:0] pick_vertex();
    if ($urandom_range(0, 3) != 0) return eoip_pkg::FROM_W'($urandom_range(0, 7) * 9);
    return eoip_pkg::FROM_W'($urandom_range(0, VERTICES - 1));
  endfunction

  // Receiver: random stall bursts, one long hold-off while the sender keeps
  // offering (the engine fills and stalls its input), then a clean tail.
  initial begin
    int unsigned burst_left;
    bit          held;
    burst_left = 0;
    held       = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && edges_taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 4) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned made;
    int unsigned steps;
    int unsigned hop;
    logic [eoip_pkg::FROM_W-1:0]   at;
    logic [eoip_pkg::TO_W-1:0]     next_at;
    logic [eoip_pkg::WEIGHT_W-1:0] weight;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    from_vertex <= '0;
    to_vertex   <= '0;
    edge_weight <= '0;
    quiet        = 1'b0;
    edges_taken  = 0;
    cycle_count  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The engine stalls its input during the clearing sweep,
    // so the first beat simply waits for it.
    // Weight zero into an empty store, then again: still a path of one.
    drive_edge(0, 0, 0);
    drive_edge(0, 0, 0);
    // A short chain of strictly rising weights, then a repeat of the last
    // weight, which must not lengthen anything.
    drive_edge(0, 1, 1);
    drive_edge(1, 2, 2);
    drive_edge(2, 3, 3);
    drive_edge(2, 3, 3);
    // Top weight, and an equal weight following it, which cannot extend.
    drive_edge(3, 63, 255);
    drive_edge(63, 0, 255);
    drive_edge(63, 63, 254);
    drive_edge(63, 63, 255);
    // Self loops with rising weights build up at one vertex.
    drive_edge(5, 5, 1);
    drive_edge(5, 5, 2);
    drive_edge(5, 5, 3);
    drive_edge(5, 5, 3);
    // Alternating bit patterns on every field, then all-ones, all-zero and top-bit values.
    drive_edge(42, 21, 8'hAA);
    drive_edge(21, 42, 8'h55);
    drive_edge(42, 21, 8'hFF);
    drive_edge(21, 42, 8'h00);
    drive_edge(63, 0, 0);
    drive_edge(0, 63, 128);

    // Random part. Most of it is chains whose weights climb in small steps
    // (a step of zero tries an equal weight); the rest is random edges.
    made = 0;
    while (made < RANDOM_EDGES) begin
      quiet = (made >= RANDOM_EDGES - QUIET_EDGES);
      if ($urandom_range(0, 9) < 7) begin
        steps  = $urandom_range(3, 12);
        at     = pick_vertex();
        weight = eoip_pkg::WEIGHT_W'($urandom_range(0, 60));
        for (int unsigned s = 0; s < steps && made < RANDOM_EDGES; s++) begin
          next_at = pick_vertex();
          drive_edge(at, next_at, weight);
          made++;
          at  = next_at;
          hop = $urandom_range(0, 6);
          if (weight > 255 - hop) break;
          weight = eoip_pkg::WEIGHT_W'(weight + hop);
        end
      end else begin
        drive_edge(eoip_pkg::FROM_W'($urandom_range(0, VERTICES - 1)),
                   eoip_pkg::TO_W'($urandom_range(0, VERTICES - 1)),
                   eoip_pkg::WEIGHT_W'($urandom_range(0, WEIGHT_LEVELS - 1)));
        made++;
      end
    end
    in_valid <= 1'b0;

    // Wait for every outstanding result, then let the engine run on for a
    // while so that any stray beat is still seen by the checker.
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
